// ----- design/mpw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpw_pkg: shared definitions for the matrix power block
// Matrix size, field layout of the stream words and the cell address helper.
// ----------------------------------------------------------------------------
package mpw_pkg;

    localparam int DIM    = 8;
    localparam int CELLS  = DIM * DIM;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int IDX_W  = 3;
    localparam int VAL_W  = 64;
    localparam int EXP_W  = 63;
    localparam int HALF_W = VAL_W / 2;

    // Bank 0 holds the loaded matrix, banks 1 to 3 are working matrices.
    localparam int BANKS  = 4;
    localparam int BANK_W = 2;

    // Input word layout, lowest bit first.
    localparam int IN_ROW_LSB   = 0;
    localparam int IN_COL_LSB   = IN_ROW_LSB + IDX_W;
    localparam int IN_VAL_LSB   = IN_COL_LSB + IDX_W;
    localparam int IN_EXP_LSB   = IN_VAL_LSB + VAL_W;
    localparam int IN_FIELDS_W  = IN_EXP_LSB + EXP_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;

    // Output word layout, lowest bit first.
    localparam int OUT_FIELDS_W = 2 * IDX_W + VAL_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef logic [VAL_W-1:0]  val_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [BANK_W-1:0] bank_t;

    localparam idx_t  LAST_IDX  = IDX_W'(DIM - 1);
    localparam bank_t BANK_SRC  = BANK_W'(0);
    localparam logic  REQ_LOAD  = 1'b0;
    localparam logic  REQ_POWER = 1'b1;

    function automatic addr_t cell_addr(input idx_t row, input idx_t col);
        cell_addr = ADDR_W'(int'(row) * DIM + int'(col));
    endfunction

endpackage

// ----- design/mpw_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpw_ram: generic RAM with one write port and two registered read ports
// Read data is registered and appears in the cycle after the address is presented.
// ----------------------------------------------------------------------------
module mpw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- design/matrix_power_wrapping.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_power_wrapping: square matrix raised to a power, wrapping arithmetic
// Holds a DIM x DIM matrix of 64-bit entries, loads one entry per transfer and
// computes A^e by square-and-multiply on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
//  Channel   Dir  Contents
//  s_axis    in   tuser: request kind; tdata: row, col, entry value, exponent
//  m_axis    out  tdata: row, col, result value; tlast: final result entry
//
//  A power transfer runs popcount(e) + floor(log2(e)) matrix products, at most
//  125, each multiply-add in five steps of the shared multiplier and adder;
//  each entry is then emitted through the read, load and output states, which
//  wait out any output stall. s_axis_tready is low from the power transfer
//  until the last result transfer. Reset clears the loaded matrix to zeros
//  through per-entry valid bits; there is no clearing pass.
// ----------------------------------------------------------------------------
module matrix_power_wrapping (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // row_index, col_index, entry_value, exponent, zero pad
    input  logic [mpw_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_row, out_col, out_value, zero pad
    output logic [mpw_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // last_entry
    output logic                           m_axis_tlast
);

    import mpw_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECIDE   = 3'd1;
    localparam logic [2:0] S_SHIFT    = 3'd2;
    localparam logic [2:0] S_MAC      = 3'd3;
    localparam logic [2:0] S_EMIT_RD  = 3'd4;
    localparam logic [2:0] S_EMIT_LD  = 3'd5;
    localparam logic [2:0] S_EMIT_OUT = 3'd6;

    localparam logic [2:0] PH_WAIT = 3'd0;
    localparam logic [2:0] PH_LL   = 3'd1;
    localparam logic [2:0] PH_LH   = 3'd2;
    localparam logic [2:0] PH_HL   = 3'd3;
    localparam logic [2:0] PH_ACC  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [2:0]       ph_reg, ph_next;
    idx_t             r_reg, r_next;
    idx_t             c_reg, c_next;
    idx_t             k_reg, k_next;
    logic             op_sq_reg, op_sq_next;
    bank_t            pow_sel_reg, pow_sel_next;
    bank_t            res_sel_reg, res_sel_next;
    logic             res_ident_reg, res_ident_next;
    logic [EXP_W-1:0] e_reg, e_next;
    val_t             acc_reg, acc_next;
    val_t             prod_reg, prod_next;
    logic [CELLS-1:0] src_valid_reg, src_valid_next;
    logic             srcv_a_reg, srcv_b_reg;
    idx_t             out_row_reg, out_row_next;
    idx_t             out_col_reg, out_col_next;
    val_t             out_value_reg, out_value_next;
    logic             out_last_reg, out_last_next;
    logic             m_tvalid_reg, m_tvalid_next;

    idx_t             in_row;
    idx_t             in_col;
    val_t             in_val;
    logic [EXP_W-1:0] in_exp;
    addr_t            load_addr;
    logic             load_we;
    logic             mac_we;
    addr_t            addr_a;
    addr_t            addr_b;
    addr_t            mac_waddr;
    bank_t            a_bank;
    bank_t            dst_bank;
    val_t             a_raw;
    val_t             b_raw;
    val_t             a_op;
    val_t             b_op;
    val_t             acc_sum;
    val_t             res_value;
    logic [HALF_W-1:0] mul_x;
    logic [HALF_W-1:0] mul_y;
    val_t             mul_p;
    logic             row_col_last;

    logic [BANKS-1:0] bank_we;
    addr_t            bank_waddr [BANKS];
    val_t             bank_wdata [BANKS];
    val_t             rdata_a [BANKS];
    val_t             rdata_b [BANKS];

    assign in_row = s_axis_tdata[IN_COL_LSB-1:IN_ROW_LSB];
    assign in_col = s_axis_tdata[IN_VAL_LSB-1:IN_COL_LSB];
    assign in_val = s_axis_tdata[IN_EXP_LSB-1:IN_VAL_LSB];
    assign in_exp = s_axis_tdata[IN_FIELDS_W-1:IN_EXP_LSB];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign load_addr = cell_addr(in_row, in_col);
    assign load_we   = s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_LOAD)
                       && (int'(in_row) < DIM) && (int'(in_col) < DIM);

    // Port A walks row r of the left operand, port B column c of the right one.
    // While emitting, port A reads the result entry at (r, c).
    assign addr_a    = (state_reg == S_MAC) ? cell_addr(r_reg, k_reg) : cell_addr(r_reg, c_reg);
    assign addr_b    = cell_addr(k_reg, c_reg);
    assign mac_waddr = cell_addr(r_reg, c_reg);

    genvar gb;
    generate
        for (gb = 0; gb < BANKS; gb++)
        begin : g_bank
            mpw_ram #(
                .WIDTH (VAL_W),
                .DEPTH (CELLS)
            ) u_bank (
                .clk     (clk),
                .we      (bank_we[gb]),
                .waddr   (bank_waddr[gb]),
                .wdata   (bank_wdata[gb]),
                .raddr_a (addr_a),
                .rdata_a (rdata_a[gb]),
                .raddr_b (addr_b),
                .rdata_b (rdata_b[gb])
            );
        end
    endgenerate

    // The product always lands in a working bank that neither operand uses.
    always_comb
    begin
        dst_bank = BANK_W'(1);
        for (int b = BANKS - 1; b >= 1; b--)
        begin
            if ((BANK_W'(b) != pow_sel_reg)
                && (res_ident_reg || (BANK_W'(b) != res_sel_reg)))
            begin
                dst_bank = BANK_W'(b);
            end
        end
    end

    always_comb
    begin
        for (int b = 0; b < BANKS; b++)
        begin
            if (b == 0)
            begin
                bank_we[b]    = load_we;
                bank_waddr[b] = load_addr;
                bank_wdata[b] = in_val;
            end
            else
            begin
                bank_we[b]    = mac_we && (dst_bank == BANK_W'(b));
                bank_waddr[b] = mac_waddr;
                bank_wdata[b] = acc_sum;
            end
        end
    end

    // Entries of the loaded matrix that were never written read as zero.
    assign a_bank = (state_reg == S_MAC && op_sq_reg) ? pow_sel_reg : res_sel_reg;
    assign a_raw  = ((a_bank == BANK_SRC) && !srcv_a_reg) ? '0 : rdata_a[a_bank];
    assign b_raw  = ((pow_sel_reg == BANK_SRC) && !srcv_b_reg) ? '0 : rdata_b[pow_sel_reg];
    assign b_op   = b_raw;

    // Until the first multiply the running result is the identity.
    assign a_op = (!op_sq_reg && res_ident_reg) ? VAL_W'(r_reg == k_reg) : a_raw;
    assign res_value = res_ident_reg ? VAL_W'(r_reg == c_reg) : a_raw;

    // Low 64 bits of a*b = aL*bL + ((aL*bH + aH*bL) << 32), one partial per cycle.
    always_comb
    begin
        unique case (ph_reg)
            PH_LH:
            begin
                mul_x = a_op[HALF_W-1:0];
                mul_y = b_op[VAL_W-1:HALF_W];
            end
            PH_HL:
            begin
                mul_x = a_op[VAL_W-1:HALF_W];
                mul_y = b_op[HALF_W-1:0];
            end
            default:
            begin
                mul_x = a_op[HALF_W-1:0];
                mul_y = b_op[HALF_W-1:0];
            end
        endcase
    end

    assign mul_p   = mul_x * mul_y;
    assign acc_sum = acc_reg + {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};
    assign row_col_last = (r_reg == LAST_IDX) && (c_reg == LAST_IDX);

    always_comb
    begin
        state_next     = state_reg;
        ph_next        = ph_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        k_next         = k_reg;
        op_sq_next     = op_sq_reg;
        pow_sel_next   = pow_sel_reg;
        res_sel_next   = res_sel_reg;
        res_ident_next = res_ident_reg;
        e_next         = e_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        src_valid_next = src_valid_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        m_tvalid_next  = m_tvalid_reg;
        mac_we         = 1'b0;

        if (load_we)
        begin
            src_valid_next[load_addr] = 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && (s_axis_tuser == REQ_POWER))
                begin
                    e_next         = in_exp;
                    res_ident_next = 1'b1;
                    pow_sel_next   = BANK_SRC;
                    r_next         = '0;
                    c_next         = '0;
                    k_next         = '0;
                    state_next     = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (e_reg == '0)
                begin
                    state_next = S_EMIT_RD;
                end
                else if (e_reg[0])
                begin
                    op_sq_next = 1'b0;
                    acc_next   = '0;
                    ph_next    = PH_WAIT;
                    state_next = S_MAC;
                end
                else
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                e_next = e_reg >> 1;
                if (e_reg[EXP_W-1:1] != '0)
                begin
                    op_sq_next = 1'b1;
                    acc_next   = '0;
                    ph_next    = PH_WAIT;
                    state_next = S_MAC;
                end
                else
                begin
                    state_next = S_EMIT_RD;
                end
            end
            S_MAC:
            begin
                unique case (ph_reg)
                    PH_WAIT:
                    begin
                        ph_next = PH_LL;
                    end
                    PH_LL:
                    begin
                        prod_next = mul_p;
                        ph_next   = PH_LH;
                    end
                    PH_LH:
                    begin
                        acc_next  = acc_reg + prod_reg;
                        prod_next = mul_p;
                        ph_next   = PH_HL;
                    end
                    PH_HL:
                    begin
                        acc_next  = acc_sum;
                        prod_next = mul_p;
                        ph_next   = PH_ACC;
                    end
                    PH_ACC:
                    begin
                        ph_next = PH_WAIT;
                        if (k_reg != LAST_IDX)
                        begin
                            acc_next = acc_sum;
                            k_next   = k_reg + IDX_W'(1);
                        end
                        else
                        begin
                            mac_we   = 1'b1;
                            acc_next = '0;
                            k_next   = '0;
                            if (c_reg != LAST_IDX)
                            begin
                                c_next = c_reg + IDX_W'(1);
                            end
                            else
                            begin
                                c_next = '0;
                                if (r_reg != LAST_IDX)
                                begin
                                    r_next = r_reg + IDX_W'(1);
                                end
                                else
                                begin
                                    r_next = '0;
                                    if (op_sq_reg)
                                    begin
                                        pow_sel_next = dst_bank;
                                        state_next   = S_DECIDE;
                                    end
                                    else
                                    begin
                                        res_sel_next   = dst_bank;
                                        res_ident_next = 1'b0;
                                        state_next     = S_SHIFT;
                                    end
                                end
                            end
                        end
                    end
                    default:
                    begin
                        ph_next = PH_WAIT;
                    end
                endcase
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                out_row_next   = r_reg;
                out_col_next   = c_reg;
                out_value_next = res_value;
                out_last_next  = row_col_last;
                m_tvalid_next  = 1'b1;
                state_next     = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                if (m_axis_tready)
                begin
                    m_tvalid_next = 1'b0;
                    if (row_col_last)
                    begin
                        r_next     = '0;
                        c_next     = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        if (c_reg != LAST_IDX)
                        begin
                            c_next = c_reg + IDX_W'(1);
                        end
                        else
                        begin
                            c_next = '0;
                            r_next = r_reg + IDX_W'(1);
                        end
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ph_reg        <= PH_WAIT;
            r_reg         <= '0;
            c_reg         <= '0;
            k_reg         <= '0;
            op_sq_reg     <= 1'b0;
            pow_sel_reg   <= BANK_SRC;
            res_sel_reg   <= BANK_W'(1);
            res_ident_reg <= 1'b1;
            src_valid_reg <= '0;
            srcv_a_reg    <= 1'b0;
            srcv_b_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            k_reg         <= k_next;
            op_sq_reg     <= op_sq_next;
            pow_sel_reg   <= pow_sel_next;
            res_sel_reg   <= res_sel_next;
            res_ident_reg <= res_ident_next;
            src_valid_reg <= src_valid_next;
            srcv_a_reg    <= src_valid_reg[addr_a];
            srcv_b_reg    <= src_valid_reg[addr_b];
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg         <= e_next;
        acc_reg       <= acc_next;
        prod_reg      <= prod_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_value_reg, out_col_reg, out_row_reg});
    assign m_axis_tlast  = out_last_reg;

    // A product must never overwrite the loaded matrix or one of its own operands.
    a_dst_free: assert property (@(posedge clk) disable iff (!rst_n)
        mac_we |-> (dst_bank != BANK_SRC) && (dst_bank != pow_sel_reg)
                   && (res_ident_reg || (dst_bank != res_sel_reg)))
        else $error("matrix product written over a live operand");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while a result is still pending");

    a_power_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_POWER))
        |=> !s_axis_tready)
        else $error("power request did not start a computation");

    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast)
        |-> (out_row_reg == LAST_IDX) && (out_col_reg == LAST_IDX))
        else $error("last marker on an entry other than the final corner");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("block not idle after the final result transfer");

endmodule

// ----- tb/mpw_result_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpw_result_check: result checker for the matrix power block
// Follows both stream channels and keeps its own copy of the loaded matrix.
// On each power transfer it raises that copy to the requested exponent,
// queues the expected entries and compares every result transfer in order.
// ----------------------------------------------------------------------------
module mpw_result_check (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    // row_index, col_index, entry_value, exponent, zero pad
    input  logic [mpw_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic                           s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_row, out_col, out_value, zero pad
    input  logic [mpw_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // last_entry
    input  logic                           m_axis_tlast,
    output int                             fault_count,
    output int                             outstanding
);

    import mpw_pkg::*;

    localparam int OUT_ROW_LSB = 0;
    localparam int OUT_COL_LSB = OUT_ROW_LSB + IDX_W;
    localparam int OUT_VAL_LSB = OUT_COL_LSB + IDX_W;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        idx_t row;
        idx_t col;
        val_t value;
        logic last;
    } result_entry_t;

    val_t held_mat [CELLS];
    val_t run_square [CELLS];
    val_t run_product [CELLS];
    val_t scratch [CELLS];

    result_entry_t expected_entries [$];
    int            mismatches = 0;
    int            queued     = 0;

    assign fault_count = mismatches;
    assign outstanding = queued;

    // Multiplies either the running product or the running square by the
    // running square, and writes the product back to the left operand.
    function automatic void multiply_by_square(input bit square_self);
        int   r;
        int   c;
        int   k;
        int   i;
        val_t sum;
        val_t lhs;
        for (r = 0; r < DIM; r++) begin
            for (c = 0; c < DIM; c++) begin
                sum = '0;
                for (k = 0; k < DIM; k++) begin
                    lhs = square_self ? run_square[r * DIM + k] : run_product[r * DIM + k];
                    sum = sum + lhs * run_square[k * DIM + c];
                end
                scratch[r * DIM + c] = sum;
            end
        end
        for (i = 0; i < CELLS; i++) begin
            if (square_self)
                run_square[i] = scratch[i];
            else
                run_product[i] = scratch[i];
        end
    endfunction

    function automatic void queue_matrix_power(input logic [EXP_W-1:0] exponent);
        logic [EXP_W-1:0] e;
        result_entry_t    expected;
        int               i;
        int               r;
        int               c;
        e = exponent;
        for (i = 0; i < CELLS; i++) begin
            run_product[i] = (i / DIM == i % DIM) ? val_t'(1) : val_t'(0);
            run_square[i]  = held_mat[i];
        end
        while (e != '0) begin
            if (e[0])
                multiply_by_square(1'b0);
            e = e >> 1;
            if (e != '0)
                multiply_by_square(1'b1);
        end
        for (r = 0; r < DIM; r++) begin
            for (c = 0; c < DIM; c++) begin
                expected.row   = idx_t'(r);
                expected.col   = idx_t'(c);
                expected.value = run_product[r * DIM + c];
                expected.last  = (r == DIM - 1) && (c == DIM - 1);
                expected_entries.push_back(expected);
            end
        end
    endfunction

    function automatic void take_request();
        idx_t row;
        idx_t col;
        row = s_axis_tdata[IN_ROW_LSB +: IDX_W];
        col = s_axis_tdata[IN_COL_LSB +: IDX_W];
        if (s_axis_tuser == REQ_LOAD) begin
            // Loads outside the matrix leave it unchanged.
            if (int'(row) < DIM && int'(col) < DIM)
                held_mat[int'(row) * DIM + int'(col)] = s_axis_tdata[IN_VAL_LSB +: VAL_W];
        end else begin
            queue_matrix_power(s_axis_tdata[IN_EXP_LSB +: EXP_W]);
        end
    endfunction

    function automatic void check_result();
        result_entry_t expected;
        result_entry_t actual;
        actual.row   = m_axis_tdata[OUT_ROW_LSB +: IDX_W];
        actual.col   = m_axis_tdata[OUT_COL_LSB +: IDX_W];
        actual.value = m_axis_tdata[OUT_VAL_LSB +: VAL_W];
        actual.last  = m_axis_tlast;
        if (expected_entries.size() == 0) begin
            if (mismatches < MAX_REPORTS)
                $display("[%0t] unexpected result: row %0d col %0d value %h last %0b",
                         $realtime, actual.row, actual.col, actual.value, actual.last);
            mismatches++;
        end else begin
            expected = expected_entries.pop_front();
            if (actual !== expected) begin
                if (mismatches < MAX_REPORTS)
                    $display({"[%0t] result mismatch: expected row %0d col %0d value %h ",
                              "last %0b, got row %0d col %0d value %h last %0b"},
                             $realtime, expected.row, expected.col, expected.value,
                             expected.last, actual.row, actual.col, actual.value,
                             actual.last);
                mismatches++;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < CELLS; i++)
                held_mat[i] = '0;
            expected_entries.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                take_request();
            if (m_axis_tvalid && m_axis_tready)
                check_result();
        end
        queued <= expected_entries.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the matrix power block
// Loads matrix entries and requests powers over the input stream, first a
// directed set of extremes, then random load and power sequences under four
// idling phases. The result checker judges every result transfer.
// ----------------------------------------------------------------------------
module tb_top;

    import mpw_pkg::*;

    localparam int CYCLE_LIMIT  = 20_000_000;
    localparam int DRAIN_CYCLES = 64;
    localparam int PHASE_ITEMS  = 22;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;
    int fault_count;
    int outstanding;

    matrix_power_wrapping u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    mpw_result_check u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fault_count   (fault_count),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic val_t random_word();
        return {$urandom, $urandom};
    endfunction

    function automatic val_t pick_entry_value();
        case ($urandom_range(3))
            0, 1:    return val_t'(int'($urandom_range(8)) - 4);
            2:       return random_word();
            default:
                case ($urandom_range(3))
                    0:       return 64'h8000_0000_0000_0000;
                    1:       return 64'h7FFF_FFFF_FFFF_FFFF;
                    2:       return 64'hFFFF_FFFF_FFFF_FFFF;
                    default: return 64'h0;
                endcase
        endcase
    endfunction

    // Each matrix product of a power request walks every multiply-add, so random
    // exponents stay small; the directed part covers the widest one.
    function automatic logic [EXP_W-1:0] pick_exponent();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6)
            return EXP_W'($urandom_range(3));
        else if (pick < 9)
            return EXP_W'($urandom_range(15, 4));
        else
            return EXP_W'(1) << $urandom_range(10, 5);
    endfunction

    task automatic send_request(input logic kind, input idx_t row, input idx_t col,
                                input val_t value, input logic [EXP_W-1:0] exponent);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= IN_DATA_W'({exponent, value, col, row});
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // The exponent field of a load transfer carries random bits.
    task automatic load_entry(input int row, input int col, input val_t value);
        send_request(REQ_LOAD, idx_t'(row), idx_t'(col), value, EXP_W'(random_word()));
    endtask

    // Row, column and value of a power transfer carry random bits.
    task automatic request_power(input logic [EXP_W-1:0] exponent);
        send_request(REQ_POWER, idx_t'($urandom_range(7)), idx_t'($urandom_range(7)),
                     random_word(), exponent);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = REQ_LOAD;
        s_axis_tdata  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The matrix is all zeros after reset: exponent zero gives the
        // identity, exponent one gives zeros.
        request_power('0);
        request_power(EXP_W'(1));

        // Extreme entries so that squares and sums wrap.
        load_entry(0, 0, 64'h7FFF_FFFF_FFFF_FFFF);
        load_entry(7, 7, 64'h8000_0000_0000_0000);
        load_entry(3, 4, 64'hFFFF_FFFF_FFFF_FFFF);
        load_entry(7, 0, 64'h1);
        load_entry(0, 7, 64'h2);
        load_entry(4, 3, 64'h3);
        request_power('0);
        request_power(EXP_W'(2));
        request_power(EXP_W'(3));
        load_entry(1, 1, 64'hFFFF_FFFF_FFFF_FFFE);
        load_entry(2, 5, 64'h0000_0001_0000_0000);
        load_entry(6, 2, 64'h0);
        request_power({EXP_W{1'b1}});

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 62;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 62;
                end
                default:
                begin
                    send_idle_pct  = 11;
                    recv_stall_pct = 11;
                end
            endcase
            repeat (PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 22)
                    request_power(pick_exponent());
                else
                    load_entry($urandom_range(7), $urandom_range(7), pick_entry_value());
            end
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
